// ----- src/mttm_pkg.sv -----
package mttm_pkg;

    localparam int NUM_TAPES_DEF       = 2;
    localparam int NUM_STATES_DEF      = 64;
    localparam int RULES_PER_STATE_DEF = 16;
    localparam int TAPE_LEN_DEF        = 1024;

    localparam logic [15:0] RESET_MAX_STEPS   = 16'd1000;
    localparam logic [5:0]  RESET_START_STATE = 6'd1;
    localparam logic [7:0]  RESET_BLANK       = 8'd95;

    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_MAX_STEPS   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_START_STATE = 2'd1;

    localparam logic [1:0] MV_NONE  = 2'd0;
    localparam logic [1:0] MV_LEFT  = 2'd1;
    localparam logic [1:0] MV_RIGHT = 2'd2;
    localparam logic [1:0] MV_STOP  = 2'd3;

    typedef enum logic [2:0] {
        CMD_LOAD_RULE  = 3'd0,
        CMD_WRITE_CELL = 3'd1,
        CMD_SET_HEAD   = 3'd2,
        CMD_READ_CELL  = 3'd3,
        CMD_RESTART    = 3'd4,
        CMD_STEP       = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        STS_DONE    = 3'd0,
        STS_STEPPED = 3'd1,
        STS_HALTED  = 3'd2,
        STS_NO_RULE = 3'd3,
        STS_OOB     = 3'd4,
        STS_LIMIT   = 3'd5,
        STS_STOPPED = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TREAD,
        S_TCAP,
        S_SCAN,
        S_EXEC,
        S_WRITE,
        S_RDWAIT,
        S_RESP
    } fsm_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] match_syms;
        logic [15:0] write_syms;
        logic [3:0]  moves;
        logic [5:0]  next_st;
    } rule_t;

endpackage

// ----- src/multi_tape_turing_machine.sv -----
// Multi-tape Turing machine. Every request gets exactly one response. After reset the
// block runs a clearing pass over max(NUM_TAPES*TAPE_LEN, NUM_STATES*RULES_PER_STATE)
// entries (2048 at default sizes) that invalidates all rules and fills the tapes with '_'
// (95); it takes no request meanwhile. Read cell passes through an extra wait state for
// the tape read before its response. A step reads each tape under its head, one tape
// at a time, then scans the state's rule slots through the single rule memory read
// port, one slot per cycle, taking the first valid slot that matches, then writes
// one tape per cycle unless a move would leave the tape. The blank symbol is fixed;
// config writes to indexes other than max steps and start state are accepted but
// have no effect.
module multi_tape_turing_machine #(
    parameter int NUM_TAPES       = mttm_pkg::NUM_TAPES_DEF,
    parameter int NUM_STATES      = mttm_pkg::NUM_STATES_DEF,
    parameter int RULES_PER_STATE = mttm_pkg::RULES_PER_STATE_DEF,
    parameter int TAPE_LEN        = mttm_pkg::TAPE_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mttm_pkg::CFG_IW-1:0] cfg_index,
    input  logic [15:0]                 cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  command,
    input  logic                        tape_select,
    input  logic [9:0]                  cell_address,
    input  logic [7:0]                  cell_symbol,
    input  logic [5:0]                  state_number,
    input  logic [3:0]                  rule_slot,
    input  logic                        rule_valid,
    input  logic [15:0]                 match_symbols,
    input  logic [15:0]                 write_symbols,
    input  logic [3:0]                  moves,
    input  logic [5:0]                  next_state,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  status,
    output logic [7:0]                  read_symbol,
    output logic [5:0]                  machine_state,
    output logic [3:0]                  matched_slot,
    output logic [15:0]                 step_count
);
    import mttm_pkg::*;

    localparam int TAPE_DEPTH = NUM_TAPES * TAPE_LEN;
    localparam int RULE_DEPTH = NUM_STATES * RULES_PER_STATE;
    localparam int CLR_DEPTH  = (TAPE_DEPTH > RULE_DEPTH) ? TAPE_DEPTH : RULE_DEPTH;
    localparam int TA  = $clog2(TAPE_DEPTH);
    localparam int RA  = $clog2(RULE_DEPTH);
    localparam int CW  = $clog2(CLR_DEPTH);
    localparam int HW  = $clog2(TAPE_LEN);
    localparam int TCW = (NUM_TAPES > 1) ? $clog2(NUM_TAPES) : 1;
    localparam int SCW = $clog2(RULES_PER_STATE + 1);

    function automatic logic [7:0] lane_byte(input logic [15:0] f, input int t);
        return (t < 2) ? 8'(f >> (8 * t)) : 8'd0;
    endfunction

    function automatic logic [1:0] lane_move(input logic [3:0] f, input int t);
        return (t < 2) ? 2'(f >> (2 * t)) : MV_NONE;
    endfunction

    // memories
    logic [7:0] tape_mem [TAPE_DEPTH];
    rule_t      rule_mem [RULE_DEPTH];
    logic          tape_we;
    logic [TA-1:0] tape_waddr, tape_raddr;
    logic [7:0]    tape_wdata, tape_rdata;
    logic          rule_we;
    logic [RA-1:0] rule_waddr, rule_raddr;
    rule_t         rule_wdata, rule_rdata;

    always_ff @(posedge clk)
    begin
        if (tape_we)
        begin
            tape_mem[tape_waddr] <= tape_wdata;
        end
        tape_rdata <= tape_mem[tape_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (rule_we)
        begin
            rule_mem[rule_waddr] <= rule_wdata;
        end
        rule_rdata <= rule_mem[rule_raddr];
    end

    // control state
    fsm_t            state_reg, state_next;
    logic [CW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [TCW-1:0]  tcnt_reg, tcnt_next;
    logic [SCW-1:0]  scan_cnt_reg, scan_cnt_next;
    logic            pend_reg, pend_next;
    logic [SCW-1:0]  pend_slot_reg, pend_slot_next;
    logic [HW-1:0]   head_reg [NUM_TAPES];
    logic [HW-1:0]   head_next [NUM_TAPES];
    logic [5:0]      cur_state_reg, cur_state_next;
    logic [15:0]     steps_reg, steps_next;
    logic            stopped_reg, stopped_next;
    logic [15:0]     max_steps_reg;
    logic [5:0]      start_state_reg;
    logic            out_valid_reg, out_valid_next;

    // payload
    logic [7:0]  sym_reg [NUM_TAPES];
    logic [7:0]  sym_next [NUM_TAPES];
    rule_t       rule_reg, rule_next;
    status_t     hold_status_reg, hold_status_next;
    logic [7:0]  hold_rd_reg, hold_rd_next;
    logic [3:0]  hold_slot_reg, hold_slot_next;
    status_t     status_reg;
    logic [7:0]  read_symbol_reg;
    logic [5:0]  machine_state_reg;
    logic [3:0]  matched_slot_reg;
    logic [15:0] step_count_reg;

    // decode
    logic          cell_ok, rule_ok, cur_ok, res_free, hit, oob, halt, last_tape;
    logic [HW-1:0] head_mv [NUM_TAPES];
    logic [TA-1:0] cell_addr, head_addr;
    logic [15:0]   steps_inc;

    always_comb
    begin
        cell_ok   = (32'(tape_select) < NUM_TAPES) && (32'(cell_address) < TAPE_LEN);
        rule_ok   = (32'(state_number) < NUM_STATES) && (32'(rule_slot) < RULES_PER_STATE);
        cur_ok    = 32'(cur_state_reg) < NUM_STATES;
        res_free  = !out_valid_reg || !out_stall;
        last_tape = 32'(tcnt_reg) == NUM_TAPES - 1;
        cell_addr = TA'(TA'(tape_select) * TA'(TAPE_LEN) + TA'(cell_address));
        head_addr = TA'(TA'(tcnt_reg) * TA'(TAPE_LEN) + TA'(head_reg[tcnt_reg]));
        steps_inc = (steps_reg == 16'hFFFF) ? steps_reg : steps_reg + 16'd1;
        hit = rule_rdata.valid;
        for (int t = 0; t < NUM_TAPES; t++)
        begin
            if (sym_reg[t] != lane_byte(rule_rdata.match_syms, t))
            begin
                hit = 1'b0;
            end
        end
        oob  = 1'b0;
        halt = 1'b0;
        for (int t = 0; t < NUM_TAPES; t++)
        begin
            head_mv[t] = head_reg[t];
            case (lane_move(rule_reg.moves, t))
                MV_LEFT:
                begin
                    if (head_reg[t] == '0)
                        oob = 1'b1;
                    else
                        head_mv[t] = head_reg[t] - HW'(1);
                end
                MV_RIGHT:
                begin
                    if (32'(head_reg[t]) == TAPE_LEN - 1)
                        oob = 1'b1;
                    else
                        head_mv[t] = head_reg[t] + HW'(1);
                end
                MV_STOP:  halt = 1'b1;
                default:  ;
            endcase
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (32'(clr_cnt_reg) == CLR_DEPTH - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd_t'(command))
                        CMD_READ_CELL: state_next = cell_ok ? S_RDWAIT : S_RESP;
                        CMD_STEP:      state_next = (!stopped_reg && cur_ok) ? S_TREAD : S_RESP;
                        default:       state_next = S_RESP;
                    endcase
                end
            end
            S_TREAD:  state_next = S_TCAP;
            S_TCAP:   state_next = last_tape ? S_SCAN : S_TREAD;
            S_SCAN:
            begin
                if (pend_reg && hit)
                    state_next = S_EXEC;
                else if (32'(scan_cnt_reg) == RULES_PER_STATE)
                    state_next = S_RESP;
            end
            S_EXEC:   state_next = oob ? S_RESP : S_WRITE;
            S_WRITE:
            begin
                if (last_tape)
                    state_next = S_RESP;
            end
            S_RDWAIT: state_next = S_RESP;
            S_RESP:
            begin
                if (res_free)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        clr_cnt_next     = clr_cnt_reg;
        tcnt_next        = tcnt_reg;
        scan_cnt_next    = scan_cnt_reg;
        pend_next        = 1'b0;
        pend_slot_next   = scan_cnt_reg;
        head_next        = head_reg;
        cur_state_next   = cur_state_reg;
        steps_next       = steps_reg;
        stopped_next     = stopped_reg;
        sym_next         = sym_reg;
        rule_next        = rule_reg;
        hold_status_next = hold_status_reg;
        hold_rd_next     = hold_rd_reg;
        hold_slot_next   = hold_slot_reg;
        out_valid_next   = out_valid_reg && out_stall;
        tape_we          = 1'b0;
        tape_waddr       = cell_addr;
        tape_wdata       = cell_symbol;
        tape_raddr       = cell_addr;
        rule_we          = 1'b0;
        rule_waddr       = RA'(RA'(state_number) * RA'(RULES_PER_STATE) + RA'(rule_slot));
        rule_wdata       = '{rule_valid, match_symbols, write_symbols, moves, next_state};
        rule_raddr       = RA'(RA'(cur_state_reg) * RA'(RULES_PER_STATE) + RA'(scan_cnt_reg));
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + CW'(1);
                tape_we      = 32'(clr_cnt_reg) < TAPE_DEPTH;
                tape_waddr   = clr_cnt_reg[TA-1:0];
                tape_wdata   = RESET_BLANK;
                rule_we      = 32'(clr_cnt_reg) < RULE_DEPTH;
                rule_waddr   = clr_cnt_reg[RA-1:0];
                rule_wdata   = '0;
            end
            S_IDLE:
            begin
                hold_status_next = STS_DONE;
                hold_rd_next     = '0;
                hold_slot_next   = '0;
                tcnt_next        = '0;
                scan_cnt_next    = '0;
                if (in_valid)
                begin
                    case (cmd_t'(command))
                        CMD_LOAD_RULE:  rule_we = rule_ok;
                        CMD_WRITE_CELL: tape_we = cell_ok;
                        CMD_SET_HEAD:
                        begin
                            if (cell_ok)
                                head_next[tape_select] = HW'(cell_address);
                        end
                        CMD_RESTART:
                        begin
                            cur_state_next = start_state_reg;
                            steps_next     = '0;
                            stopped_next   = 1'b0;
                        end
                        CMD_STEP:
                        begin
                            if (stopped_reg)
                                hold_status_next = STS_STOPPED;
                            else if (!cur_ok)
                            begin
                                hold_status_next = STS_NO_RULE;
                                stopped_next     = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_TREAD:  tape_raddr = head_addr;
            S_TCAP:
            begin
                sym_next[tcnt_reg] = tape_rdata;
                tcnt_next          = last_tape ? '0 : tcnt_reg + TCW'(1);
            end
            S_SCAN:
            begin
                if (32'(scan_cnt_reg) < RULES_PER_STATE)
                begin
                    scan_cnt_next = scan_cnt_reg + SCW'(1);
                    pend_next     = 1'b1;
                end
                if (pend_reg && hit)
                begin
                    pend_next      = 1'b0;
                    rule_next      = rule_rdata;
                    hold_slot_next = 4'(pend_slot_reg);
                end
                else if (32'(scan_cnt_reg) == RULES_PER_STATE)
                begin
                    hold_status_next = STS_NO_RULE;
                    stopped_next     = 1'b1;
                end
            end
            S_EXEC:
            begin
                tcnt_next = '0;
                if (oob)
                begin
                    hold_status_next = STS_OOB;
                    stopped_next     = 1'b1;
                end
            end
            S_WRITE:
            begin
                tape_we    = 1'b1;
                tape_waddr = head_addr;
                tape_wdata = (32'(tcnt_reg) < 2) ?
                             8'(rule_reg.write_syms >> (8 * 32'(tcnt_reg))) : 8'd0;
                tcnt_next  = tcnt_reg + TCW'(1);
                if (last_tape)
                begin
                    head_next      = head_mv;
                    cur_state_next = rule_reg.next_st;
                    steps_next     = steps_inc;
                    if (halt)
                    begin
                        hold_status_next = STS_HALTED;
                        stopped_next     = 1'b1;
                    end
                    else if (steps_inc >= max_steps_reg)
                    begin
                        hold_status_next = STS_LIMIT;
                        stopped_next     = 1'b1;
                    end
                    else
                        hold_status_next = STS_STEPPED;
                end
            end
            S_RDWAIT: hold_rd_next = tape_rdata;
            S_RESP:
            begin
                if (res_free)
                    out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            tcnt_reg      <= '0;
            scan_cnt_reg  <= '0;
            pend_reg      <= 1'b0;
            cur_state_reg <= RESET_START_STATE;
            steps_reg     <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < NUM_TAPES; t++)
            begin
                head_reg[t] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            tcnt_reg      <= tcnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            pend_reg      <= pend_next;
            cur_state_reg <= cur_state_next;
            steps_reg     <= steps_next;
            stopped_reg   <= stopped_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_steps_reg   <= RESET_MAX_STEPS;
            start_state_reg <= RESET_START_STATE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_STEPS:   max_steps_reg   <= cfg_data;
                CFG_START_STATE: start_state_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        pend_slot_reg   <= pend_slot_next;
        sym_reg         <= sym_next;
        rule_reg        <= rule_next;
        hold_status_reg <= hold_status_next;
        hold_rd_reg     <= hold_rd_next;
        hold_slot_reg   <= hold_slot_next;
        if (state_reg == S_RESP && res_free)
        begin
            status_reg        <= hold_status_reg;
            read_symbol_reg   <= hold_rd_reg;
            machine_state_reg <= cur_state_reg;
            matched_slot_reg  <= hold_slot_reg;
            step_count_reg    <= steps_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign read_symbol   = read_symbol_reg;
    assign machine_state = machine_state_reg;
    assign matched_slot  = matched_slot_reg;
    assign step_count    = step_count_reg;

    a_stop_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(stopped_reg) |-> (hold_status_reg == STS_HALTED || hold_status_reg == STS_NO_RULE
            || hold_status_reg == STS_OOB || hold_status_reg == STS_LIMIT))
        else $error("stop without a stopping status");

    a_step_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (steps_reg != $past(steps_reg)) |->
            (steps_reg == 16'($past(steps_reg) + 16'd1) || steps_reg == '0))
        else $error("step count jumped");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (32'(scan_cnt_reg) <= RULES_PER_STATE))
        else $error("scan ran past the last slot");

    a_resp_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && state_reg != S_RESP) |=> !out_valid_reg)
        else $error("response issued outside the response state");

endmodule
